/* src/ftsm_pkg.sv */
// shared constants and the control type for the frame time trimmed mean smoother
package ftsm_pkg;

    localparam int WINDOW_LEN_DEF  = 11;
    localparam int SAMPLE_BITS_DEF = 24;
    localparam int FRAC_BITS       = 4;
    localparam int DROP_COUNT      = 4;

    typedef struct packed {
        logic clear;
        logic scan;
        logic commit;
    } ctl_t;

endpackage

/* src/ftsm_window.sv */
// history window of smoothed values as a rotating shift register
module ftsm_window #(
    parameter int WINDOW_LEN = ftsm_pkg::WINDOW_LEN_DEF,
    parameter int VALUE_W    = ftsm_pkg::SAMPLE_BITS_DEF + ftsm_pkg::FRAC_BITS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  ftsm_pkg::ctl_t     ctl,
    input  logic [VALUE_W-1:0] new_value,
    output logic [VALUE_W-1:0] head
);

    logic [VALUE_W-1:0] win_reg [WINDOW_LEN];

    assign head = win_reg[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < WINDOW_LEN; i++)
            begin
                win_reg[i] <= '0;
            end
        end
        else if (ctl.scan || ctl.commit)
        begin
            for (int i = 0; i < WINDOW_LEN - 1; i++)
            begin
                win_reg[i] <= win_reg[i + 1];
            end
            win_reg[WINDOW_LEN - 1] <= ctl.commit ? new_value : win_reg[0];
        end
    end

endmodule

/* src/ftsm_stats.sv */
// running sum and two smallest / two largest tracker over the window scan
module ftsm_stats #(
    parameter int VALUE_W = ftsm_pkg::SAMPLE_BITS_DEF + ftsm_pkg::FRAC_BITS,
    parameter int SUM_W   = VALUE_W + 4
) (
    input  logic               clk,
    input  ftsm_pkg::ctl_t     ctl,
    input  logic [VALUE_W-1:0] sample,
    output logic [SUM_W-1:0]   trimmed
);

    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [VALUE_W-1:0] min1_reg, min1_next, min2_reg, min2_next;
    logic [VALUE_W-1:0] max1_reg, max1_next, max2_reg, max2_next;

    always_comb
    begin
        sum_next  = sum_reg;
        min1_next = min1_reg;
        min2_next = min2_reg;
        max1_next = max1_reg;
        max2_next = max2_reg;
        if (ctl.clear)
        begin
            sum_next  = '0;
            min1_next = '1;
            min2_next = '1;
            max1_next = '0;
            max2_next = '0;
        end
        else if (ctl.scan)
        begin
            sum_next = sum_reg + SUM_W'(sample);
            if (sample < min1_reg)
            begin
                min2_next = min1_reg;
                min1_next = sample;
            end
            else if (sample < min2_reg)
            begin
                min2_next = sample;
            end
            if (sample > max1_reg)
            begin
                max2_next = max1_reg;
                max1_next = sample;
            end
            else if (sample > max2_reg)
            begin
                max2_next = sample;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        min1_reg <= min1_next;
        min2_reg <= min2_next;
        max1_reg <= max1_next;
        max2_reg <= max2_next;
    end

    assign trimmed = sum_reg - SUM_W'(min1_reg) - SUM_W'(min2_reg)
                   - SUM_W'(max1_reg) - SUM_W'(max2_reg);

endmodule

/* src/ftsm_div.sv */
// divider by a constant through reciprocal multiplication, one byte of the reciprocal per cycle
module ftsm_div #(
    parameter int SUM_W   = 32,
    parameter int VALUE_W = 28,
    parameter int DIVISOR = 7
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [SUM_W-1:0]   dividend,
    output logic               done,
    output logic [VALUE_W-1:0] quotient
);

    localparam int DIGIT_W = 8;
    localparam int LOG_D   = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int SHIFT   = SUM_W + LOG_D;
    localparam int DIGITS  = (SUM_W + 1 + DIGIT_W - 1) / DIGIT_W;
    localparam int MAG_W   = DIGITS * DIGIT_W;
    localparam int ACC_W   = SUM_W + MAG_W;
    localparam int PART_W  = SUM_W + DIGIT_W;
    localparam int CW      = (DIGITS > 1) ? $clog2(DIGITS) : 1;
    localparam logic [63:0] RECIP =
        ((64'd1 << SHIFT) + 64'(DIVISOR - 1)) / 64'(DIVISOR);
    localparam logic [MAG_W-1:0] RECIP_V   = MAG_W'(RECIP);
    localparam logic [CW-1:0]    LAST_STEP = CW'(DIGITS - 1);

    logic [SUM_W-1:0]  num_reg, num_next;
    logic [MAG_W-1:0]  mag_reg, mag_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [PART_W-1:0] partial;

    assign partial = PART_W'(num_reg) * PART_W'(mag_reg[MAG_W-1 -: DIGIT_W]);

    always_comb
    begin
        num_next  = num_reg;
        mag_next  = mag_reg;
        acc_next  = acc_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start)
        begin
            num_next = dividend;
            mag_next = RECIP_V;
            acc_next = '0;
            cnt_next = '0;
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            acc_next = (acc_reg << DIGIT_W) + ACC_W'(partial);
            mag_next = mag_reg << DIGIT_W;
            cnt_next = cnt_reg + CW'(1);
            if (cnt_reg == LAST_STEP)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        mag_reg <= mag_next;
        acc_reg <= acc_next;
    end

    assign done     = done_reg;
    assign quotient = acc_reg[SHIFT +: VALUE_W];

endmodule

/* src/frame_time_trimmed_mean_smoother_core.sv */
// top level of the frame time trimmed mean smoother with its sequencer
//
//  channel  | dir | fields (tdata, lowest bit first)
//  s_axis   | in  | frame_time [SAMPLE_BITS-1:0], integer microseconds
//  m_axis   | out | smoothed_time [SAMPLE_BITS+3:0], Q.4 microseconds
//
//  an item runs a scan of the window through the sum/min/max tracker,
//  then a trim step, the reciprocal divider and a commit step, and then
//  the sequencer returns to idle to take the next item
//  reset clears the window to zeros and empties the output register
//  a stalled result holds in the output register; the next item is taken
//  meanwhile and waits at its commit step until the register frees
module frame_time_trimmed_mean_smoother_core #(
    parameter int WINDOW_LEN  = ftsm_pkg::WINDOW_LEN_DEF,
    parameter int SAMPLE_BITS = ftsm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // frame_time
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    output logic [((SAMPLE_BITS+4+7)/8)*8-1:0]     m_axis_tdata   // smoothed_time
);

    localparam int VALUE_W = SAMPLE_BITS + ftsm_pkg::FRAC_BITS;
    localparam int SUM_W   = VALUE_W + $clog2(WINDOW_LEN);
    localparam int KEPT    = WINDOW_LEN - ftsm_pkg::DROP_COUNT;
    localparam int OUT_W   = ((VALUE_W + 7) / 8) * 8;
    localparam int CNT_W   = $clog2(WINDOW_LEN);
    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(WINDOW_LEN - 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_TRIM = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_DONE = 3'd4;

    logic [2:0]         state_reg, state_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic [VALUE_W-1:0] x_reg, x_next;
    logic               m_valid_reg, m_valid_next;
    logic [VALUE_W-1:0] m_data_reg, m_data_next;

    ftsm_pkg::ctl_t     ctl;
    logic               accept;
    logic [VALUE_W-1:0] head;
    logic [SUM_W-1:0]   trimmed;
    logic               div_done;
    logic [VALUE_W-1:0] quotient;
    logic [VALUE_W:0]   mid_sum;
    logic [VALUE_W-1:0] result;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign ctl.clear  = accept;
    assign ctl.scan   = (state_reg == ST_SCAN);
    assign ctl.commit = (state_reg == ST_DONE) && (!m_valid_reg || m_axis_tready);

    assign mid_sum = {1'b0, x_reg} + {1'b0, quotient};
    assign result  = mid_sum[VALUE_W:1];

    ftsm_window #(
        .WINDOW_LEN (WINDOW_LEN),
        .VALUE_W    (VALUE_W)
    ) u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .new_value (result),
        .head      (head)
    );

    ftsm_stats #(
        .VALUE_W (VALUE_W),
        .SUM_W   (SUM_W)
    ) u_stats (
        .clk     (clk),
        .ctl     (ctl),
        .sample  (head),
        .trimmed (trimmed)
    );

    ftsm_div #(
        .SUM_W   (SUM_W),
        .VALUE_W (VALUE_W),
        .DIVISOR (KEPT)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_TRIM),
        .dividend (trimmed),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        x_next       = x_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    x_next     = VALUE_W'(s_axis_tdata[SAMPLE_BITS-1:0]) << ftsm_pkg::FRAC_BITS;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cnt_next = cnt_reg + CNT_W'(1);
                if (cnt_reg == SCAN_LAST)
                begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (ctl.commit)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = result;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        m_data_reg <= m_data_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'(m_data_reg);

endmodule

/* src/ftsm_checker.sv */
// port-level checks for the frame time trimmed mean smoother
module ftsm_checker #(
    parameter int TDATA_W = 32
) (
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata
);

    // a transfer in keeps input ready low as the scan begins
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready ##1 !s_axis_tready)
        else $error("input ready returned too soon after a transfer");

    // a new result only appears out of a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        ($rose(m_axis_tvalid)) |-> !$past(s_axis_tready))
        else $error("result appeared without work in progress");

    // fresh results only come from the commit step while busy
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready && $past(s_axis_tready)) |=> !m_axis_tvalid)
        else $error("result emitted without a transfer in");

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result changed");

endmodule

bind frame_time_trimmed_mean_smoother_core ftsm_checker #(
    .TDATA_W (((SAMPLE_BITS + 4 + 7) / 8) * 8)
) u_ftsm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* dv/frame_time_trimmed_mean_smoother_core_tb.sv */
// testbench for the frame time trimmed mean smoother: directed table, random frames, scoreboard
module frame_time_trimmed_mean_smoother_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WIN      = ftsm_pkg::WINDOW_LEN_DEF;
    localparam int SBITS    = ftsm_pkg::SAMPLE_BITS_DEF;
    localparam int FBITS    = ftsm_pkg::FRAC_BITS;
    localparam int DROP     = ftsm_pkg::DROP_COUNT;
    localparam int VAL_W    = SBITS + FBITS;
    localparam int IN_W     = ((SBITS + 7) / 8) * 8;
    localparam int OUT_W    = ((SBITS + 4 + 7) / 8) * 8;
    localparam int N_RANDOM = 650;
    localparam int N_ROWS   = 25;
    localparam int IDLE_LIMIT = 2000;
    localparam logic [SBITS-1:0] FT_MAX = '1;

    typedef struct {
        logic [SBITS-1:0] frame_time;
        bit               typed;
        logic [VAL_W-1:0] smoothed;
    } frame_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_W-1:0] s_axis_tdata = '0;    // frame_time
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_W-1:0] m_axis_tdata;        // smoothed_time

    logic [VAL_W-1:0] history [WIN];
    logic [VAL_W-1:0] smoothed_q [$];
    frame_row_t       typed_q [$];
    bit               steady_phase = 1'b0;
    int               err_count = 0;
    int               idle_cycles = 0;

    frame_row_t frame_rows [N_ROWS] = '{
        '{24'h000000, 1'b1, 28'h0000000},
        '{24'hFFFFFF, 1'b1, 28'h7FFFFF8},
        '{24'hFFFFFF, 1'b1, 28'h7FFFFF8},
        '{24'hFFFFFF, 1'b1, 28'h7FFFFF8},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0},
        '{24'h000000, 1'b0, 28'h0},
        '{24'h000000, 1'b0, 28'h0},
        '{24'h000000, 1'b0, 28'h0},
        '{24'd16667,  1'b0, 28'h0},
        '{24'd16667,  1'b0, 28'h0},
        '{24'd16667,  1'b0, 28'h0},
        '{24'h555555, 1'b0, 28'h0},
        '{24'hAAAAAA, 1'b0, 28'h0},
        '{24'h000001, 1'b0, 28'h0},
        '{24'h800000, 1'b0, 28'h0},
        '{24'd16667,  1'b0, 28'h0},
        '{24'h000000, 1'b0, 28'h0},
        '{24'hFFFFFF, 1'b0, 28'h0}
    };

    frame_time_trimmed_mean_smoother_core u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 clk = ~clk;

    // trimmed mean of the window, midpoint with the new frame, window shift
    function automatic logic [VAL_W-1:0] smooth_frame(logic [SBITS-1:0] frame_time);
        logic [VAL_W-1:0] ordered [WIN];
        logic [VAL_W-1:0] v;
        logic [VAL_W+7:0] total;
        logic [VAL_W:0]   mean;
        logic [VAL_W:0]   mid;
        int j;
        total = '0;
        for (int i = 0; i < WIN; i++)
        begin
            v = history[i];
            j = i;
            while (j > 0 && ordered[j-1] > v)
            begin
                ordered[j] = ordered[j-1];
                j--;
            end
            ordered[j] = v;
        end
        for (int i = DROP / 2; i < WIN - DROP / 2; i++)
            total += (VAL_W+8)'(ordered[i]);
        mean = (VAL_W+1)'(total / (WIN - DROP));
        mid = ({1'b0, frame_time, {FBITS{1'b0}}} + mean) >> 1;
        for (int i = 0; i < WIN - 1; i++)
            history[i] = history[i+1];
        history[WIN-1] = mid[VAL_W-1:0];
        return mid[VAL_W-1:0];
    endfunction

    // input side: predict on each accepted transfer
    always @(posedge clk)
    begin
        frame_row_t row;
        logic [VAL_W-1:0] predicted;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            row = typed_q.pop_front();
            predicted = smooth_frame(s_axis_tdata[SBITS-1:0]);
            smoothed_q.push_back(row.typed ? row.smoothed : predicted);
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge clk)
    begin
        logic [VAL_W-1:0] want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (smoothed_q.size() == 0)
            begin
                $display("%0t: unexpected smoothed_time, expected none, actual %h",
                         $time, m_axis_tdata[VAL_W-1:0]);
                err_count++;
            end
            else
            begin
                want = smoothed_q.pop_front();
                if (m_axis_tdata[VAL_W-1:0] !== want)
                begin
                    $display("%0t: smoothed_time mismatch, expected %h, actual %h",
                             $time, want, m_axis_tdata[VAL_W-1:0]);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // receiver stalls
    initial
    begin : sink
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = steady_phase ? 0 : $urandom_range(0, 9);
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
        end
    end

    initial
    begin : source
        frame_row_t row;
        logic [SBITS-1:0] last_ft;
        logic [SBITS-1:0] base_ft;
        int gap;
        int kind;
        int total;
        foreach (history[k])
            history[k] = '0;
        last_ft = '0;
        base_ft = 24'd16667;
        total = N_ROWS + N_RANDOM;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        for (int n = 0; n < total; n++)
        begin
            if (n % 64 == 0)
                steady_phase = ($urandom_range(0, 3) == 0);
            if (n < N_ROWS)
                row = frame_rows[n];
            else
            begin
                row.typed = 1'b0;
                row.smoothed = '0;
                kind = $urandom_range(0, 9);
                if (n % 50 == 0)
                    base_ft = SBITS'($urandom_range(4000, 60000));
                case (kind)
                    0, 1, 2, 3: row.frame_time = base_ft + SBITS'($urandom_range(0, 4000)) - 24'd2000;
                    4, 5:       row.frame_time = SBITS'($urandom);
                    6:          row.frame_time = last_ft;
                    7:          row.frame_time = SBITS'($urandom_range(0, 15));
                    8:          row.frame_time = $urandom_range(0, 1) ? FT_MAX : '0;
                    default:
                    begin
                        row.frame_time = SBITS'(1) << $urandom_range(0, SBITS - 1);
                        if ($urandom_range(0, 1))
                            row.frame_time = ~row.frame_time;
                    end
                endcase
            end
            last_ft = row.frame_time;
            gap = steady_phase ? 0 : $urandom_range(0, 9);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            typed_q.push_back(row);
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= IN_W'(row.frame_time);
            do @(posedge clk); while (!s_axis_tready);
        end
        s_axis_tvalid <= 1'b0;
        while (smoothed_q.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

/* files.f */
src/ftsm_pkg.sv
src/ftsm_window.sv
src/ftsm_stats.sv
src/ftsm_div.sv
src/frame_time_trimmed_mean_smoother_core.sv
src/ftsm_checker.sv
dv/frame_time_trimmed_mean_smoother_core_tb.sv
